// ===== hw/rtl/boot_region_bump_allocator_assert.svh =====
// assertion macros shared by the region allocator modules
// expects clk and rst_n in the scope of each use
`ifndef BOOT_REGION_BUMP_ALLOCATOR_ASSERT_SVH
`define BOOT_REGION_BUMP_ALLOCATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define BRA_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("region allocator invariant violated");

// consequent holds in the same cycle as the antecedent
`define BRA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("region allocator implication violated");

// consequent holds in the cycle after the antecedent
`define BRA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("region allocator sequence violated");

`endif

// ===== hw/rtl/bra_pkg.sv =====
// shared types, codes and defaults for the boot region allocator
// no dependencies
`timescale 1ns / 1ps

package bra_pkg;

    // parameter defaults
    localparam int SLOTS_DEFAULT      = 16;
    localparam int PAGE_SHIFT_DEFAULT = 12;

    // request actions
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // region kinds
    localparam logic [1:0] KIND_AVAILABLE = 2'd1;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_KERNEL = 3'd2;
    localparam logic [2:0] ST_KIND   = 3'd3;
    localparam logic [2:0] ST_ORDER  = 3'd4;
    localparam logic [2:0] ST_SMALL  = 3'd5;
    localparam logic [2:0] ST_NO_FIT = 3'd7;

    // configuration register indexes
    localparam logic CFG_KERNEL_BASE  = 1'b0;
    localparam logic CFG_KERNEL_LIMIT = 1'b1;

    localparam logic [31:0] KERNEL_BASE_RESET  = 32'h0010_0000;
    localparam logic [31:0] KERNEL_LIMIT_RESET = 32'h0020_0000;

    localparam logic [20:0] TOP_PAGE_MAX = 21'h1F_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] base_address;
        logic [31:0] limit_address;
        logic [1:0]  mem_kind;
        logic [31:0] request_bytes;
        logic [4:0]  align_log2;
    } bra_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] alloc_address;
        logic [20:0] highest_page;
    } bra_rsp_t;

    // one stored region
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] limit;
        logic [1:0]  kind;
    } bra_slot_t;

    // completion report of a worker unit
    typedef struct packed {
        logic       fin;
        logic [2:0] status;
    } bra_fin_t;

endpackage

// ===== hw/rtl/bra_table.sv =====
// region table storage: one write port, one registered read port
// depends on bra_pkg
`timescale 1ns / 1ps

module bra_table
    import bra_pkg::*;
#(
    parameter int  REGION_SLOTS = SLOTS_DEFAULT,
    localparam int IDX_W        = $clog2(REGION_SLOTS)
)(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  bra_slot_t        wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output bra_slot_t        rd_data
);

    bra_slot_t mem [REGION_SLOTS];
    bra_slot_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bra_region.sv =====
// add path: page rounding, region checks, kernel clip or split, store
// also owns the fill count and the highest page; depends on bra_pkg
`timescale 1ns / 1ps

module bra_region
    import bra_pkg::*;
#(
    parameter int  REGION_SLOTS = SLOTS_DEFAULT,
    parameter int  PAGE_SHIFT   = PAGE_SHIFT_DEFAULT,
    localparam int IDX_W        = $clog2(REGION_SLOTS),
    localparam int CNT_W        = $clog2(REGION_SLOTS + 1)
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic             clear,
    input  logic [31:0]      base_address,
    input  logic [31:0]      limit_address,
    input  logic [1:0]       mem_kind,
    input  logic [31:0]      kernel_base,
    input  logic [31:0]      kernel_limit,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_idx,
    output bra_slot_t        wr_data,
    output logic [CNT_W-1:0] count,
    output logic [20:0]      highest_next,
    output bra_fin_t         fin
);

    localparam logic [32:0]      PAGE_MASK  = (33'd1 << PAGE_SHIFT) - 33'd1;
    localparam logic [32:0]      PAGE_BYTES = 33'd1 << PAGE_SHIFT;
    localparam logic [CNT_W-1:0] SLOTS_CNT  = CNT_W'(REGION_SLOTS);

    localparam logic [1:0] R_IDLE  = 2'd0;
    localparam logic [1:0] R_CHECK = 2'd1;
    localparam logic [1:0] R_STORE = 2'd2;

    function automatic logic [32:0] page_up(input logic [31:0] a);
        return ({1'b0, a} + PAGE_MASK) & ~PAGE_MASK;
    endfunction

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [20:0]      top_reg, top_next;
    logic [32:0]      s_reg, s_next;
    logic [32:0]      e_reg, e_next;
    logic [32:0]      ks_reg, ks_next;
    logic [32:0]      ke_reg, ke_next;
    logic [32:0]      pend_e_reg, pend_e_next;
    logic             pend_reg, pend_next;
    logic             split_reg, split_next;
    logic [1:0]       kind_reg, kind_next;
    logic [2:0]       acc_reg, acc_next;

    logic [32:0] span;
    logic [2:0]  chk;
    logic [2:0]  acc_merged;
    logic [32:0] pfn;
    logic [20:0] pfn_sat;

    // checks on the current region, in priority order
    assign span = e_reg - s_reg;

    always_comb
    begin
        if (count_reg >= SLOTS_CNT)
        begin
            chk = ST_FULL;
        end
        else if (s_reg >= ks_reg && e_reg < ke_reg)
        begin
            chk = ST_KERNEL;
        end
        else if (kind_reg > KIND_AVAILABLE)
        begin
            chk = ST_KIND;
        end
        else if (s_reg > e_reg)
        begin
            chk = ST_ORDER;
        end
        else if (span < PAGE_BYTES)
        begin
            chk = ST_SMALL;
        end
        else
        begin
            chk = ST_OK;
        end
    end

    // first failing half wins
    assign acc_merged = (acc_reg != ST_OK) ? acc_reg : chk;

    // page number of the stored end, saturated
    assign pfn     = e_reg >> PAGE_SHIFT;
    assign pfn_sat = (pfn > {12'd0, TOP_PAGE_MAX}) ? TOP_PAGE_MAX : pfn[20:0];

    // add sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        ks_next     = ks_reg;
        ke_next     = ke_reg;
        pend_e_next = pend_e_reg;
        pend_next   = pend_reg;
        split_next  = split_reg;
        kind_next   = kind_reg;
        acc_next    = acc_reg;
        fin.fin     = 1'b0;
        fin.status  = acc_reg;

        unique case (state_reg)
            R_IDLE:
            begin
                if (go)
                begin
                    s_next     = page_up(base_address);
                    e_next     = {1'b0, limit_address & ~PAGE_MASK[31:0]};
                    ks_next    = page_up(kernel_base);
                    ke_next    = page_up(kernel_limit);
                    kind_next  = mem_kind;
                    split_next = 1'b1;
                    pend_next  = 1'b0;
                    acc_next   = ST_OK;
                    state_next = R_CHECK;
                end
            end
            R_CHECK:
            begin
                if (chk != ST_OK)
                begin
                    acc_next = acc_merged;
                    if (pend_reg)
                    begin
                        s_next    = ke_reg;
                        e_next    = pend_e_reg;
                        pend_next = 1'b0;
                    end
                    else
                    begin
                        fin.fin    = 1'b1;
                        fin.status = acc_merged;
                        state_next = R_IDLE;
                    end
                end
                else if (split_reg && s_reg < ks_reg && e_reg > ke_reg)
                begin
                    // region surrounds the kernel: lower half now, upper half later
                    pend_next   = 1'b1;
                    pend_e_next = e_reg;
                    e_next      = ks_reg;
                    split_next  = 1'b0;
                end
                else
                begin
                    // clip a partial overlap
                    if (s_reg < ks_reg && e_reg > ks_reg)
                    begin
                        e_next = ks_reg;
                    end
                    else if (s_reg < ke_reg && e_reg > ke_reg)
                    begin
                        s_next = ke_reg;
                    end
                    state_next = R_STORE;
                end
            end
            R_STORE:
            begin
                count_next = count_reg + CNT_W'(1);
                if (pfn_sat > top_reg)
                begin
                    top_next = pfn_sat;
                end
                if (pend_reg)
                begin
                    s_next     = ke_reg;
                    e_next     = pend_e_reg;
                    pend_next  = 1'b0;
                    state_next = R_CHECK;
                end
                else
                begin
                    fin.fin    = 1'b1;
                    fin.status = acc_reg;
                    state_next = R_IDLE;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase

        if (clear)
        begin
            count_next = '0;
            top_next   = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            count_reg <= '0;
            top_reg   <= '0;
            pend_reg  <= 1'b0;
            split_reg <= 1'b0;
            acc_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            pend_reg  <= pend_next;
            split_reg <= split_next;
            acc_reg   <= acc_next;
        end
    end

    // region payload
    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        e_reg      <= e_next;
        ks_reg     <= ks_next;
        ke_reg     <= ke_next;
        pend_e_reg <= pend_e_next;
        kind_reg   <= kind_next;
    end

    // table write at the fill count
    assign wr_en        = (state_reg == R_STORE);
    assign wr_idx       = count_reg[IDX_W-1:0];
    assign wr_data      = '{base: s_reg[31:0], limit: e_reg[31:0], kind: kind_reg};
    assign count        = count_reg;
    assign highest_next = top_next;

`include "boot_region_bump_allocator_assert.svh"

    `BRA_ASSERT_HOLDS(a_count_bound, count_reg <= SLOTS_CNT)
    `BRA_ASSERT_IMPLIES(a_store_room, wr_en, count_reg < SLOTS_CNT)
    `BRA_ASSERT_IMPLIES(a_pend_no_split, pend_reg, !split_reg)

endmodule

// ===== hw/rtl/bra_scan.sv =====
// alloc path: pipelined first-fit walk over the stored regions
// read, align, fit check, then bump the granted region; depends on bra_pkg
`timescale 1ns / 1ps

module bra_scan
    import bra_pkg::*;
#(
    parameter int  REGION_SLOTS = SLOTS_DEFAULT,
    localparam int IDX_W        = $clog2(REGION_SLOTS),
    localparam int CNT_W        = $clog2(REGION_SLOTS + 1)
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [CNT_W-1:0] count,
    input  logic [31:0]      request_bytes,
    input  logic [4:0]       align_log2,
    output logic             rd_en,
    output logic [IDX_W-1:0] rd_idx,
    input  bra_slot_t        rd_data,
    output logic             wr_en,
    output logic [IDX_W-1:0] wr_idx,
    output bra_slot_t        wr_data,
    output bra_fin_t         fin,
    output logic [31:0]      address
);

    logic             run_reg, run_next;
    logic             issue_reg, issue_next;
    logic [CNT_W-1:0] next_reg, next_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic [IDX_W-1:0] idx1_reg;
    logic [IDX_W-1:0] idx2_reg;
    logic [32:0]      aligned_reg;
    logic [31:0]      limit_reg;
    logic [31:0]      mask_reg;
    logic [31:0]      bytes_reg;

    logic        issue_now;
    logic [32:0] aligned1;
    logic        usable1;
    logic [33:0] diff;
    logic        fit;
    logic        drained;

    // read issue
    assign issue_now = issue_reg && (next_reg < count);
    assign rd_en     = issue_now;
    assign rd_idx    = next_reg[IDX_W-1:0];

    // align stage: round the region start up, one extra bit against wrap
    assign aligned1 = ({1'b0, rd_data.base} + {1'b0, mask_reg}) & ~{1'b0, mask_reg};
    assign usable1  = v1_reg && (rd_data.kind == KIND_AVAILABLE);

    // fit stage: room between aligned start and region end
    assign diff = {2'b00, limit_reg} - {1'b0, aligned_reg};
    assign fit  = v2_reg && !diff[33] && (diff != '0) && (diff[32:0] >= {1'b0, bytes_reg});

    assign drained = run_reg && !issue_reg && !v1_reg && !v2_reg;

    assign fin.fin    = fit || drained;
    assign fin.status = fit ? ST_OK : ST_NO_FIT;
    assign address    = aligned_reg[31:0];

    // bump the granted region
    assign wr_en   = fit;
    assign wr_idx  = idx2_reg;
    assign wr_data = '{base: aligned_reg[31:0] + bytes_reg, limit: limit_reg,
                       kind: KIND_AVAILABLE};

    // walk control
    always_comb
    begin
        run_next   = run_reg;
        issue_next = issue_reg;
        next_next  = next_reg;
        v1_next    = issue_now;
        v2_next    = usable1;

        if (go)
        begin
            run_next   = 1'b1;
            issue_next = 1'b1;
            next_next  = '0;
            v1_next    = 1'b0;
            v2_next    = 1'b0;
        end
        else if (fit)
        begin
            // first fit found: stop and flush
            run_next   = 1'b0;
            issue_next = 1'b0;
            v1_next    = 1'b0;
            v2_next    = 1'b0;
        end
        else if (drained)
        begin
            run_next = 1'b0;
        end
        else if (issue_reg)
        begin
            if (issue_now)
            begin
                next_next = next_reg + CNT_W'(1);
            end
            else
            begin
                issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            issue_reg <= 1'b0;
            next_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            issue_reg <= issue_next;
            next_reg  <= next_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
    end

    // request and pipeline payload
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mask_reg  <= (32'd1 << align_log2) - 32'd1;
            bytes_reg <= request_bytes;
        end
        idx1_reg    <= next_reg[IDX_W-1:0];
        idx2_reg    <= idx1_reg;
        aligned_reg <= aligned1;
        limit_reg   <= rd_data.limit;
    end

endmodule

// ===== hw/rtl/boot_region_bump_allocator.sv =====
// boot region table with first-fit bump allocator, top level
// done rises the cycle after the work ends: clear and unused actions end in the cycle they are taken,
// add runs longer when a region is split around the kernel,
// alloc ends at the first fitting slot, or after walking every stored region for no fit (table walk)
// one request at a time; a new one is taken in the cycle done is shown
// reset empties the table and loads the kernel window defaults; no stall input
`timescale 1ns / 1ps

module boot_region_bump_allocator
    import bra_pkg::*;
#(
    parameter int REGION_SLOTS = SLOTS_DEFAULT,
    parameter int PAGE_SHIFT   = PAGE_SHIFT_DEFAULT
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  bra_req_t    request,
    output logic        done,
    output bra_rsp_t    result,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IDX_W = $clog2(REGION_SLOTS);
    localparam int CNT_W = $clog2(REGION_SLOTS + 1);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_ADD   = 2'd1;
    localparam logic [1:0] T_ALLOC = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        done_reg, done_next;
    bra_rsp_t    result_reg, result_next;
    logic [31:0] kbase_reg;
    logic [31:0] klimit_reg;

    logic add_go;
    logic alloc_go;
    logic clear_go;

    logic             add_wr_en;
    logic [IDX_W-1:0] add_wr_idx;
    bra_slot_t        add_wr_data;
    logic [CNT_W-1:0] count;
    logic [20:0]      highest_next;
    bra_fin_t         add_fin;

    logic             scan_rd_en;
    logic [IDX_W-1:0] scan_rd_idx;
    bra_slot_t        tbl_rd_data;
    logic             scan_wr_en;
    logic [IDX_W-1:0] scan_wr_idx;
    bra_slot_t        scan_wr_data;
    bra_fin_t         alloc_fin;
    logic [31:0]      alloc_addr;

    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_idx;
    bra_slot_t        tbl_wr_data;

    assign busy = (state_reg != T_IDLE);

    // kernel window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbase_reg  <= KERNEL_BASE_RESET;
            klimit_reg <= KERNEL_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KERNEL_BASE:  kbase_reg  <= cfg_data;
                CFG_KERNEL_LIMIT: klimit_reg <= cfg_data;
            endcase
        end
    end

    // dispatch and result capture
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        add_go      = 1'b0;
        alloc_go    = 1'b0;
        clear_go    = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    unique case (request.action)
                        ACT_ADD:
                        begin
                            add_go     = 1'b1;
                            state_next = T_ADD;
                        end
                        ACT_ALLOC:
                        begin
                            alloc_go   = 1'b1;
                            state_next = T_ALLOC;
                        end
                        ACT_CLEAR:
                        begin
                            clear_go    = 1'b1;
                            done_next   = 1'b1;
                            result_next = '{status: ST_OK, alloc_address: '0,
                                            highest_page: highest_next};
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{status: ST_OK, alloc_address: '0,
                                            highest_page: highest_next};
                        end
                    endcase
                end
            end
            T_ADD:
            begin
                if (add_fin.fin)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: add_fin.status, alloc_address: '0,
                                    highest_page: highest_next};
                    state_next  = T_IDLE;
                end
            end
            T_ALLOC:
            begin
                if (alloc_fin.fin)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: alloc_fin.status,
                                    alloc_address: (alloc_fin.status == ST_OK) ? alloc_addr : '0,
                                    highest_page: highest_next};
                    state_next  = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // table write port shared by add and alloc
    assign tbl_wr_en   = add_wr_en | scan_wr_en;
    assign tbl_wr_idx  = add_wr_en ? add_wr_idx : scan_wr_idx;
    assign tbl_wr_data = add_wr_en ? add_wr_data : scan_wr_data;

    bra_table #(
        .REGION_SLOTS (REGION_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_idx  (tbl_wr_idx),
        .wr_data (tbl_wr_data),
        .rd_en   (scan_rd_en),
        .rd_idx  (scan_rd_idx),
        .rd_data (tbl_rd_data)
    );

    bra_region #(
        .REGION_SLOTS (REGION_SLOTS),
        .PAGE_SHIFT   (PAGE_SHIFT)
    ) u_region (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (add_go),
        .clear         (clear_go),
        .base_address  (request.base_address),
        .limit_address (request.limit_address),
        .mem_kind      (request.mem_kind),
        .kernel_base   (kbase_reg),
        .kernel_limit  (klimit_reg),
        .wr_en         (add_wr_en),
        .wr_idx        (add_wr_idx),
        .wr_data       (add_wr_data),
        .count         (count),
        .highest_next  (highest_next),
        .fin           (add_fin)
    );

    bra_scan #(
        .REGION_SLOTS (REGION_SLOTS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (alloc_go),
        .count         (count),
        .request_bytes (request.request_bytes),
        .align_log2    (request.align_log2),
        .rd_en         (scan_rd_en),
        .rd_idx        (scan_rd_idx),
        .rd_data       (tbl_rd_data),
        .wr_en         (scan_wr_en),
        .wr_idx        (scan_wr_idx),
        .wr_data       (scan_wr_data),
        .fin           (alloc_fin),
        .address       (alloc_addr)
    );

`include "boot_region_bump_allocator_assert.svh"

    `BRA_ASSERT_IMPLIES(a_done_idle, done, !busy)
    `BRA_ASSERT_NEXT(a_add_busy, start && !busy && request.action == ACT_ADD, busy)
    `BRA_ASSERT_IMPLIES(a_one_writer, add_wr_en, !scan_wr_en)

endmodule
